FILE: rtl/railcom_detector_frame_decoder_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the detector frame decoder
// Both macros sample on clk and are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef RAILCOM_DETECTOR_FRAME_DECODER_CORE_MACROS_SVH
`define RAILCOM_DETECTOR_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication
`define RFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rfd_pkg.sv
// ---------------------------------------------------------------------------
// rfd_pkg
// Types and byte codes shared by the detector frame decoder modules.
// ---------------------------------------------------------------------------
package rfd_pkg;

  // Start bytes and frame trailer
  localparam logic [7:0] START_DIAG  = 8'hD1;
  localparam logic [7:0] START_OFF   = 8'hFA;
  localparam logic [7:0] START_ADDR  = 8'hFC;
  localparam logic [7:0] START_SYS   = 8'hFD;
  localparam logic [7:0] START_CV    = 8'hFE;
  localparam logic [7:0] CLOSE_BYTE  = 8'hFF;

  // Data byte counts per start byte
  localparam logic [3:0] LEN_DIAG = 4'd10;
  localparam logic [3:0] LEN_OFF  = 4'd0;
  localparam logic [3:0] LEN_ADDR = 4'd3;
  localparam logic [3:0] LEN_SYS  = 4'd4;
  localparam logic [3:0] LEN_CV   = 4'd2;

  // Address word handling
  localparam logic [7:0]  HI_MASK     = 8'hBF;
  localparam logic [13:0] ADDR_LIMIT  = 14'h27FF;
  localparam logic [13:0] ADDR_FORCED = 14'h3FFF;

  // Device reinit command
  localparam logic [7:0] TX_REINIT = 8'h20;

  typedef enum logic [1:0] {
    EVT_ADDR = 2'd0,
    EVT_CV   = 2'd1,
    EVT_TX   = 2'd2
  } evt_kind_t;

  // A frame that closed this cycle and needs evaluation
  typedef struct packed {
    logic       valid;
    evt_kind_t  kind;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } close_t;

endpackage

FILE: rtl/rfd_in_if.sv
// ---------------------------------------------------------------------------
// rfd_in_if
// Received byte channel: valid/ready with one link byte per word.
// ---------------------------------------------------------------------------
interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/rfd_out_if.sv
// ---------------------------------------------------------------------------
// rfd_out_if
// Report channel: valid/ready with one decoded event per word.
// ---------------------------------------------------------------------------
interface rfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  detector;
  logic [13:0] loco_address;
  logic        heading_right;
  logic        occupied;
  logic [7:0]  cv_value;
  logic [7:0]  tx_byte;

  modport source (
    output valid, output event_kind, output detector, output loco_address,
    output heading_right, output occupied, output cv_value, output tx_byte,
    input ready
  );
  modport sink (
    input valid, input event_kind, input detector, input loco_address,
    input heading_right, input occupied, input cv_value, input tx_byte,
    output ready
  );
endinterface

FILE: rtl/rfd_frame_parser.sv
// ---------------------------------------------------------------------------
// rfd_frame_parser
// Tracks frame boundaries on the byte stream, keeps the first four bytes of
// a frame and flags the closing trailer of frames that produce a report.
// ---------------------------------------------------------------------------
module rfd_frame_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  output rfd_pkg::close_t close
);
  import rfd_pkg::*;

  logic       in_frame, in_frame_next;
  logic [3:0] expected_length, expected_length_next;
  logic [3:0] byte_index, byte_index_next;
  logic [7:0] frame_bytes [4];

  logic       start_hit;
  logic [3:0] start_len;
  logic [3:0] idx_m1;
  logic       closing;
  logic       fb_we;
  logic [1:0] fb_addr;

  // Start byte decode
  always_comb begin
    start_hit = 1'b1;
    start_len = LEN_OFF;
    case (rx_byte)
      START_DIAG: start_len = LEN_DIAG;
      START_OFF:  start_len = LEN_OFF;
      START_ADDR: start_len = LEN_ADDR;
      START_SYS:  start_len = LEN_SYS;
      START_CV:   start_len = LEN_CV;
      default:    start_hit = 1'b0;
    endcase
  end

  // Frame sequencing
  always_comb begin
    in_frame_next        = in_frame;
    expected_length_next = expected_length;
    byte_index_next      = byte_index;
    idx_m1               = byte_index - 4'd1;
    closing              = 1'b0;
    fb_we                = 1'b0;
    fb_addr              = 2'd0;
    if (take) begin
      if (!in_frame) begin
        if (start_hit) begin
          in_frame_next        = 1'b1;
          expected_length_next = start_len;
          byte_index_next      = 4'd1;
          fb_we                = 1'b1;
          fb_addr              = 2'd0;
        end
      end else if (idx_m1 == expected_length && rx_byte == CLOSE_BYTE) begin
        closing              = 1'b1;
        in_frame_next        = 1'b0;
        expected_length_next = 4'd0;
        byte_index_next      = 4'd0;
      end else if (idx_m1 < expected_length) begin
        // only the first four bytes are kept
        fb_we           = (byte_index < 4'd4);
        fb_addr         = byte_index[1:0];
        byte_index_next = byte_index + 4'd1;
      end
    end
  end

  // Report-producing frames leave on the trailer byte
  always_comb begin
    close.valid = 1'b0;
    close.kind  = EVT_ADDR;
    close.b1    = frame_bytes[1];
    close.b2    = frame_bytes[2];
    close.b3    = frame_bytes[3];
    case (frame_bytes[0])
      START_ADDR: begin
        close.valid = closing;
        close.kind  = EVT_ADDR;
      end
      START_CV: begin
        close.valid = closing;
        close.kind  = EVT_CV;
      end
      START_SYS: begin
        close.valid = closing;
        close.kind  = EVT_TX;
      end
      default: close.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      expected_length <= 4'd0;
      byte_index      <= 4'd0;
    end else begin
      in_frame        <= in_frame_next;
      expected_length <= expected_length_next;
      byte_index      <= byte_index_next;
    end
  end

  // Frame byte buffer, no reset needed
  always_ff @(posedge clk) begin
    if (fb_we) begin
      frame_bytes[fb_addr] <= rx_byte;
    end
  end

endmodule

FILE: rtl/rfd_evaluator.sv
// ---------------------------------------------------------------------------
// rfd_evaluator
// Evaluates closed frames: address frames are checked against the
// per-detector last-address store, cv and system frames pass straight to
// the report register.
// ---------------------------------------------------------------------------
`include "railcom_detector_frame_decoder_core_macros.svh"

module rfd_evaluator #(
  parameter int MAX_DETECTOR = 239
) (
  input  logic             clk,
  input  logic             rst,
  input  rfd_pkg::close_t  close,
  output logic             stall,
  rfd_out_if.source        report
);
  import rfd_pkg::*;

  localparam int         IDX_W     = (MAX_DETECTOR > 1) ? $clog2(MAX_DETECTOR) : 1;
  localparam logic [7:0] MAX_DET_B = 8'(MAX_DETECTOR);

  // Last-address store with per-entry valid bits
  logic [14:0]             store [MAX_DETECTOR];
  logic [MAX_DETECTOR-1:0] vbits;
  logic [14:0]             rd_data;
  logic                    rd_vld;

  // Stage 1: frame waiting for compare
  logic             s1_valid;
  evt_kind_t        s1_kind;
  logic [7:0]       s1_det;
  logic [IDX_W-1:0] s1_idx;
  logic [14:0]      s1_packed;
  logic [13:0]      s1_loco;
  logic             s1_heading;
  logic [7:0]       s1_cv;

  // Report register
  logic        out_valid;
  evt_kind_t   out_kind;
  logic [7:0]  out_det;
  logic [13:0] out_loco;
  logic        out_heading;
  logic        out_occ;
  logic [7:0]  out_cv;
  logic [7:0]  out_tx;

  logic             det_ok;
  logic             s1_load;
  logic [7:0]       det_m1;
  logic [IDX_W-1:0] load_idx;
  logic [15:0]      raw_addr;
  logic             forced;
  logic [14:0]      ld_packed;
  logic [13:0]      ld_loco;
  logic             s1_adv;
  logic [14:0]      stored;
  logic             changed;
  logic             emit;
  logic             wr_en;

  // Load side: range check and address word
  always_comb begin
    det_ok    = (close.b1 != 8'd0) && (close.b1 <= MAX_DET_B);
    s1_load   = close.valid && (close.kind != EVT_ADDR || det_ok);
    det_m1    = close.b1 - 8'd1;
    load_idx  = det_m1[IDX_W-1:0];
    raw_addr  = {close.b2 & HI_MASK, close.b3};
    forced    = raw_addr[13:0] > ADDR_LIMIT;
    ld_packed = forced ? {1'b0, ADDR_FORCED} : {raw_addr[15], raw_addr[13:0]};
    ld_loco   = forced ? 14'd0 : raw_addr[13:0];
  end

  // Compare side
  always_comb begin
    s1_adv  = s1_valid && (!out_valid || report.ready);
    stored  = rd_vld ? rd_data : 15'd0;
    changed = (s1_packed != stored);
    emit    = (s1_kind != EVT_ADDR) || changed;
    wr_en   = s1_adv && (s1_kind == EVT_ADDR) && changed;
    stall   = s1_valid && !s1_adv;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      vbits     <= '0;
    end else begin
      s1_valid <= s1_load || (s1_valid && !s1_adv);
      if (s1_adv && emit) begin
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        vbits[s1_idx] <= 1'b1;
      end
    end
  end

  // Store access: registered read on load, write on a changed address
  always_ff @(posedge clk) begin
    if (s1_load) begin
      rd_data <= store[load_idx];
      rd_vld  <= vbits[load_idx];
    end
    if (wr_en) begin
      store[s1_idx] <= s1_packed;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind    <= close.kind;
      s1_det     <= close.b1;
      s1_idx     <= load_idx;
      s1_packed  <= ld_packed;
      s1_loco    <= ld_loco;
      s1_heading <= !close.b2[7];
      s1_cv      <= close.b2;
    end
  end

  // Report payload; fields outside the event kind stay zero
  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_kind    <= s1_kind;
      out_det     <= 8'd0;
      out_loco    <= 14'd0;
      out_heading <= 1'b0;
      out_occ     <= 1'b0;
      out_cv      <= 8'd0;
      out_tx      <= 8'd0;
      case (s1_kind)
        EVT_ADDR: begin
          out_det     <= s1_det;
          out_loco    <= s1_loco;
          out_heading <= s1_heading;
          out_occ     <= (s1_packed != 15'd0);
        end
        EVT_CV:  out_cv <= s1_cv;
        EVT_TX:  out_tx <= TX_REINIT;
        default: out_tx <= 8'd0;
      endcase
    end
  end

  assign report.valid         = out_valid;
  assign report.event_kind    = out_kind;
  assign report.detector      = out_det;
  assign report.loco_address  = out_loco;
  assign report.heading_right = out_heading;
  assign report.occupied      = out_occ;
  assign report.cv_value      = out_cv;
  assign report.tx_byte       = out_tx;

  // A frame needs at least two bytes, so a new one cannot close while
  // stage 1 is still occupied; this also keeps store read and write apart.
  `RFD_ASSERT_NOW(a_load_when_free, s1_load, !s1_valid, "frame closed while stage 1 busy")
  `RFD_ASSERT_NEXT(a_write_reports, wr_en, out_valid, "store written without a report")
  `RFD_ASSERT_NOW(a_addr_fields_clean, out_valid && out_kind == EVT_ADDR,
                  out_cv == 8'd0 && out_tx == 8'd0, "address report carries cv or tx data")

endmodule

FILE: rtl/railcom_detector_frame_decoder_core.sv
// The closing 0xFF byte loads its frame into stage 1, then the report register.
// Throughput: one byte per cycle; input stalls only while a report waits in
// the output register and another closed frame sits in the compare stage.
// The 239-entry last-address store is read into a register ahead of compare.
// Reset (synchronous, rst high) clears frame state and the store valid bits at
// once; the block is ready to take bytes as soon as rst is low.
// ---------------------------------------------------------------------------
// railcom_detector_frame_decoder_core
// Detector link frame decoder: frames bytes and emits address, cv and
// transmit reports.
// ---------------------------------------------------------------------------
module railcom_detector_frame_decoder_core #(
  parameter int MAX_DETECTOR = 239
) (
  input logic       clk,
  input logic       rst,
  rfd_in_if.sink    rx,
  rfd_out_if.source report
);
  import rfd_pkg::*;

  close_t close;
  logic   stall;
  logic   take;

  assign rx.ready = !stall;
  assign take     = rx.valid && rx.ready;

  rfd_frame_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .close   (close)
  );

  rfd_evaluator #(
    .MAX_DETECTOR (MAX_DETECTOR)
  ) u_eval (
    .clk    (clk),
    .rst    (rst),
    .close  (close),
    .stall  (stall),
    .report (report)
  );

endmodule

FILE: tb/railcom_detector_frame_decoder_core_test.sv
// ---------------------------------------------------------------------------
// railcom_detector_frame_decoder_core_test
// Drives link bytes into the frame decoder and checks every report against a
// byte-level decoder kept in the bench. A short directed run is followed by
// mostly well-formed random frames, run four times under different amounts
// of source idling and sink back-pressure.
// ---------------------------------------------------------------------------
module railcom_detector_frame_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfd_pkg::*;

  localparam int MAX_DET      = 239;
  localparam int BYTES_TOTAL  = 1250;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PRINT_LIMIT  = 100;
  localparam int SETTLE_TICKS = 20;

  typedef struct packed {
    evt_kind_t   kind;
    logic [7:0]  detector;
    logic [13:0] loco_address;
    logic        heading_right;
    logic        occupied;
    logic [7:0]  cv_value;
    logic [7:0]  tx_byte;
  } loco_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rfd_in_if  rx_bus ();
  rfd_out_if rpt_bus ();

  railcom_detector_frame_decoder_core #(
    .MAX_DETECTOR(MAX_DET)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_bus),
    .report (rpt_bus)
  );

  always #6 clk = ~clk;

  // Bench-side decoder state
  logic        in_frame;
  logic [3:0]  frame_len;
  logic [3:0]  frame_pos;
  logic [7:0]  frame_buf [4];
  logic [14:0] last_addr_store [1:MAX_DET];

  logic [7:0]   link_bytes [$];
  loco_report_t expected_reports [$];
  int bytes_queued = 0;
  int bytes_taken  = 0;
  int error_count  = 0;
  int quiet_cycles = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit close_junk_on  = 1'b0;

  // Generator-side copy of the last address word sent per detector
  logic [15:0] last_sent_word [256];
  bit          last_sent_seen [256];

  initial begin
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    rpt_bus.ready  = 1'b0;
    in_frame  = 1'b0;
    frame_len = '0;
    frame_pos = '0;
    for (int i = 0; i < 4; i++) frame_buf[i] = '0;
    for (int d = 1; d <= MAX_DET; d++) last_addr_store[d] = '0;
    for (int d = 0; d < 256; d++) last_sent_seen[d] = 1'b0;
  end

  task automatic note_error(input string msg);
    begin
      // keep the log short when the block is badly off
      if (error_count < PRINT_LIMIT) $display("mismatch: %s", msg);
      error_count++;
    end
  endtask

  // Decode one accepted byte and queue the report it closes, if any
  task automatic decode_byte(input logic [7:0] c);
    loco_report_t r;
    logic [15:0] addr;
    logic [14:0] packed_addr;
    logic [7:0]  det;
    logic [7:0]  hi;
    logic [3:0]  len;
    bit          is_start;
    begin
      r = '0;
      if (!in_frame) begin
        is_start = 1'b1;
        len = '0;
        case (c)
          START_DIAG: len = LEN_DIAG;
          START_OFF:  len = LEN_OFF;
          START_ADDR: len = LEN_ADDR;
          START_SYS:  len = LEN_SYS;
          START_CV:   len = LEN_CV;
          default:    is_start = 1'b0;
        endcase
        if (is_start) begin
          in_frame     = 1'b1;
          frame_len    = len;
          frame_buf[0] = c;
          frame_pos    = 4'd1;
        end
      end else if (frame_pos - 4'd1 == frame_len && c == CLOSE_BYTE) begin
        in_frame  = 1'b0;
        frame_len = '0;
        frame_pos = '0;
        case (frame_buf[0])
          START_ADDR: begin
            det = frame_buf[1];
            hi  = frame_buf[2];
            if (det != 8'd0 && det <= MAX_DET) begin
              addr = {hi & HI_MASK, frame_buf[3]};
              if (addr[13:0] > ADDR_LIMIT) addr = {2'b00, ADDR_FORCED};
              packed_addr = {addr[15], addr[13:0]};
              if (packed_addr != last_addr_store[det]) begin
                last_addr_store[det] = packed_addr;
                r.kind          = EVT_ADDR;
                r.detector      = det;
                r.loco_address  = (addr == {2'b00, ADDR_FORCED}) ? 14'd0 : addr[13:0];
                r.heading_right = ~hi[7];
                r.occupied      = (addr != 16'd0);
                expected_reports.push_back(r);
              end
            end
          end
          START_CV: begin
            r.kind     = EVT_CV;
            r.cv_value = frame_buf[2];
            expected_reports.push_back(r);
          end
          START_SYS: begin
            r.kind    = EVT_TX;
            r.tx_byte = TX_REINIT;
            expected_reports.push_back(r);
          end
          default: ;
        endcase
      end else if (frame_pos - 4'd1 < frame_len) begin
        if (frame_pos < 4'd4) frame_buf[frame_pos[1:0]] = c;
        frame_pos = frame_pos + 4'd1;
      end
    end
  endtask

  // Compare one accepted report with the oldest expectation
  task automatic check_report();
    loco_report_t want;
    begin
      if (expected_reports.size() == 0) begin
        note_error($sformatf("unexpected report, kind %0d detector %0d",
                             rpt_bus.event_kind, rpt_bus.detector));
      end else begin
        want = expected_reports.pop_front();
        if (rpt_bus.event_kind !== want.kind)
          note_error($sformatf("event_kind %0d, want %0d", rpt_bus.event_kind, want.kind));
        if (rpt_bus.detector !== want.detector)
          note_error($sformatf("detector %0d, want %0d", rpt_bus.detector, want.detector));
        if (rpt_bus.loco_address !== want.loco_address)
          note_error($sformatf("loco_address %h, want %h",
                               rpt_bus.loco_address, want.loco_address));
        if (rpt_bus.heading_right !== want.heading_right)
          note_error($sformatf("heading_right %b, want %b",
                               rpt_bus.heading_right, want.heading_right));
        if (rpt_bus.occupied !== want.occupied)
          note_error($sformatf("occupied %b, want %b", rpt_bus.occupied, want.occupied));
        if (rpt_bus.cv_value !== want.cv_value)
          note_error($sformatf("cv_value %h, want %h", rpt_bus.cv_value, want.cv_value));
        if (rpt_bus.tx_byte !== want.tx_byte)
          note_error($sformatf("tx_byte %h, want %h", rpt_bus.tx_byte, want.tx_byte));
      end
    end
  endtask

  // Byte driver: offers the next pending word once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      rx_bus.valid <= 1'b0;
    end else begin
      if (rx_bus.valid && rx_bus.ready) begin
        decode_byte(rx_bus.rx_byte);
        bytes_taken++;
      end
      if (!rx_bus.valid || rx_bus.ready) begin
        if (link_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          rx_bus.valid   <= 1'b1;
          rx_bus.rx_byte <= link_bytes.pop_front();
        end else begin
          rx_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rpt_bus.ready <= 1'b0;
    end else begin
      if (rpt_bus.valid && rpt_bus.ready) check_report();
      rpt_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (rx_bus.valid && rx_bus.ready) || (rpt_bus.valid && rpt_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic [7:0] b);
    begin
      link_bytes.push_back(b);
      bytes_queued++;
    end
  endtask

  // Trailer, sometimes preceded by bytes that must be ignored
  task automatic send_close();
    int n;
    begin
      if (close_junk_on && $urandom_range(9) == 0) begin
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) send(8'($urandom_range(254)));
      end
      send(CLOSE_BYTE);
    end
  endtask

  task automatic send_addr(input logic [7:0] det, input logic [7:0] hi, input logic [7:0] lo);
    begin
      send(START_ADDR);
      send(det);
      send(hi);
      send(lo);
      send_close();
    end
  endtask

  task automatic send_frame(input logic [7:0] start, input int data_len);
    begin
      send(start);
      for (int i = 0; i < data_len; i++) send(8'($urandom_range(255)));
      send_close();
    end
  endtask

  // One random chunk of link traffic, mostly well-formed frames
  task automatic add_random_traffic();
    int pick;
    int n;
    logic [7:0] det;
    logic [7:0] hi;
    logic [7:0] lo;
    begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        case ($urandom_range(9))
          0:       det = 8'($urandom_range(255));
          1:       det = $urandom_range(1) ? 8'(MAX_DET) : 8'($urandom_range(MAX_DET + 1, 255));
          default: det = 8'($urandom_range(1, 6));
        endcase
        hi = 8'($urandom_range(255));
        lo = 8'($urandom_range(255));
        case ($urandom_range(9))
          0, 1, 2: begin
            // repeat the last word, possibly with the masked bit flipped
            if (last_sent_seen[det]) begin
              {hi, lo} = last_sent_word[det];
              if ($urandom_range(1)) hi = hi ^ 8'h40;
            end
          end
          3: begin
            // low 14 bits past the limit
            hi = 8'(($urandom_range(3) << 6) | $urandom_range(8'h28, 8'h3F));
            if ($urandom_range(1)) lo = 8'h00;
          end
          4: begin
            hi = 8'($urandom_range(3) << 6);
            lo = 8'h00;
          end
          5: begin
            hi = 8'(($urandom_range(3) << 6) | 8'h27);
            lo = 8'hFF;
          end
          default: ;
        endcase
        last_sent_word[det] = {hi, lo};
        last_sent_seen[det] = 1'b1;
        send_addr(det, hi, lo);
      end else if (pick < 68) begin
        send_frame(START_CV, LEN_CV);
      end else if (pick < 78) begin
        send_frame(START_SYS, LEN_SYS);
      end else if (pick < 84) begin
        send_frame(START_DIAG, LEN_DIAG);
      end else if (pick < 88) begin
        send_frame(START_OFF, LEN_OFF);
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_drained();
    begin
      while (bytes_taken != bytes_queued || expected_reports.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    int phase_target;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray byte, off frame, long-flag address on the top detector,
    // start values as data, wrong trailer on a system frame, detector zero
    send(8'h55);
    send(START_OFF);
    send(CLOSE_BYTE);
    send_addr(8'(MAX_DET), 8'h80, 8'h00);
    send(START_CV);
    send(START_ADDR);
    send(CLOSE_BYTE);
    send(CLOSE_BYTE);
    send(START_SYS);
    send(8'h00);
    send(CLOSE_BYTE);
    send(START_DIAG);
    send(START_CV);
    send(8'h00);
    send(CLOSE_BYTE);
    send_addr(8'h00, 8'h3F, 8'hFF);
    wait_drained();

    // Random traffic under four idling profiles
    close_junk_on = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 79; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 79; end
        default: begin src_idle_pct = 31; sink_stall_pct = 31; end
      endcase
      phase_target = bytes_queued + (BYTES_TOTAL - 24) / 4;
      while (bytes_queued < phase_target) add_random_traffic();
      wait_drained();
    end

    repeat (SETTLE_TICKS) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rfd_pkg.sv
rtl/rfd_in_if.sv
rtl/rfd_out_if.sv
rtl/rfd_frame_parser.sv
rtl/rfd_evaluator.sv
rtl/railcom_detector_frame_decoder_core.sv
tb/railcom_detector_frame_decoder_core_test.sv
